/* rtl/tfs_pkg.sv */
// Shared types and constants for the telemetry frame serializer.
// Used by tfs_sequencer and telemetry_frame_serializer; no dependencies.
package tfs_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEST_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_HOP_BUDGET   = 2'd1;
  localparam logic [1:0] CFG_PORT_NUMBER  = 2'd2;

  // Register reset values.
  localparam logic [31:0] DEST_RESET = 32'hFFFF_FFFF;
  localparam logic [6:0]  HOP_RESET  = 7'd3;
  localparam logic [6:0]  PORT_RESET = 7'd67;

  // Frame header and protobuf tag bytes.
  localparam logic [7:0] SYNC_0       = 8'h94;
  localparam logic [7:0] SYNC_1       = 8'hC3;
  localparam logic [7:0] TAG_PACKET   = 8'h0A;
  localparam logic [7:0] TAG_DEST     = 8'h15;
  localparam logic [7:0] TAG_DECODED  = 8'h22;
  localparam logic [7:0] TAG_PORT     = 8'h08;
  localparam logic [7:0] TAG_PAYLOAD  = 8'h12;
  localparam logic [7:0] TAG_TIME     = 8'h0D;
  localparam logic [7:0] TAG_ENV      = 8'h1A;
  localparam logic [7:0] TAG_HOP      = 8'h48;

  // Environment field tags: temperature, humidity, pressure, illuminance.
  localparam logic [7:0] ENV_TAG [4] = '{8'h0D, 8'h15, 8'h1D, 8'h4D};

  // Fixed length offsets on top of the environment length.
  localparam logic [7:0] TEL_EXTRA = 8'd7;
  localparam logic [7:0] DAT_EXTRA = 8'd11;
  localparam logic [7:0] PKT_EXTRA = 8'd20;
  localparam logic [7:0] TOR_EXTRA = 8'd22;

  // Shift controls from the sequencer to the byte shifters.
  typedef struct packed {
    logic       load;
    logic       dest_shift;
    logic [3:0] env_shift;
  } shift_ctrl_t;

endpackage

/* rtl/tfs_byte_shifter.sv */
// One 32-bit word that leaves one byte per cycle while shift is high, low byte first.
// Depends on nothing; instantiated by telemetry_frame_serializer.
module tfs_byte_shifter (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] load_word,
  input  logic        shift,
  output logic [7:0]  low_byte
);

  logic [31:0] word;

  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
    end else if (shift) begin
      word <= {8'h00, word[31:8]};
    end
  end

  assign low_byte = word[7:0];

endmodule

/* rtl/tfs_sequencer.sv */
// Frame sequencer: walks header, nested lengths, present environment fields
// and trailer, one byte per cycle except while an absent field is skipped. Depends on tfs_pkg.
module tfs_sequencer
  import tfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [3:0]        present_in,
  input  logic [6:0]        hop_budget,
  input  logic [6:0]        port_number,
  input  logic [7:0]        dest_byte,
  input  logic [3:0][7:0]   env_byte,
  output shift_ctrl_t       ctrl,
  output logic              busy,
  output logic              strobe,
  output logic [7:0]        byte_out,
  output logic              last_byte
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_ENV  = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  localparam logic [4:0] HEAD_LAST  = 5'd23;
  localparam logic [2:0] PHASE_LAST = 3'd4;

  logic [1:0] state, state_next;
  logic [4:0] pos, pos_next;
  logic [1:0] idx, idx_next;
  logic [2:0] phase, phase_next;
  logic [3:0] present;
  logic [4:0] env_len;
  logic       strobe_next;
  logic [7:0] byte_next;
  logic       last_next;
  logic [2:0] count;
  logic [7:0] env_len8;

  assign count    = 3'($countones(present_in));
  assign env_len8 = {3'b000, env_len};
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    pos_next    = pos;
    idx_next    = idx;
    phase_next  = phase;
    strobe_next = 1'b0;
    byte_next   = 8'h00;
    last_next   = 1'b0;
    ctrl        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_HEAD;
          pos_next   = 5'd0;
          ctrl.load  = 1'b1;
        end
      end
      S_HEAD: begin
        strobe_next = 1'b1;
        case (pos) inside
          5'd0:            byte_next = SYNC_0;
          5'd1:            byte_next = SYNC_1;
          5'd3:            byte_next = env_len8 + TOR_EXTRA;
          5'd4:            byte_next = TAG_PACKET;
          5'd5:            byte_next = env_len8 + PKT_EXTRA;
          5'd6:            byte_next = TAG_DEST;
          [5'd7:5'd10]: begin
            byte_next       = dest_byte;
            ctrl.dest_shift = 1'b1;
          end
          5'd11:           byte_next = TAG_DECODED;
          5'd12:           byte_next = env_len8 + DAT_EXTRA;
          5'd13:           byte_next = TAG_PORT;
          5'd14:           byte_next = {1'b0, port_number};
          5'd15:           byte_next = TAG_PAYLOAD;
          5'd16:           byte_next = env_len8 + TEL_EXTRA;
          5'd17:           byte_next = TAG_TIME;
          5'd22:           byte_next = TAG_ENV;
          5'd23:           byte_next = env_len8;
          default:         byte_next = 8'h00;
        endcase
        if (pos == HEAD_LAST) begin
          state_next = S_ENV;
          idx_next   = 2'd0;
          phase_next = 3'd0;
        end else begin
          pos_next = pos + 5'd1;
        end
      end
      S_ENV: begin
        if (present[idx]) begin
          strobe_next = 1'b1;
          if (phase == 3'd0) begin
            byte_next = ENV_TAG[idx];
          end else begin
            byte_next           = env_byte[idx];
            ctrl.env_shift[idx] = 1'b1;
          end
        end
        if (!present[idx] || phase == PHASE_LAST) begin
          phase_next = 3'd0;
          if (idx == 2'd3) begin
            state_next = S_TAIL;
          end else begin
            idx_next = idx + 2'd1;
          end
        end else begin
          phase_next = phase + 3'd1;
        end
      end
      S_TAIL: begin
        strobe_next = 1'b1;
        if (phase == 3'd0) begin
          byte_next  = TAG_HOP;
          phase_next = 3'd1;
        end else begin
          byte_next  = {1'b0, hop_budget};
          last_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= 5'd0;
      idx       <= 2'd0;
      phase     <= 3'd0;
      strobe    <= 1'b0;
      last_byte <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      idx       <= idx_next;
      phase     <= phase_next;
      strobe    <= strobe_next;
      last_byte <= last_next;
    end
  end

  // Output byte register, and sample-dependent bookkeeping captured when a request is taken.
  always_ff @(posedge clk) begin
    byte_out <= byte_next;
    if (ctrl.load) begin
      present <= present_in;
      env_len <= {count, 2'b00} + {2'b00, count};
    end
  end

`ifndef NO_ASSERTIONS
  a_last_has_strobe : assert property (@(posedge clk) disable iff (rst)
    last_byte |-> strobe) else $error("last byte flagged without strobe");
  a_last_ends_frame : assert property (@(posedge clk) disable iff (rst)
    strobe && last_byte |-> state == S_IDLE) else $error("frame did not end after last byte");
  a_no_strobe_at_start : assert property (@(posedge clk) disable iff (rst)
    accept && state == S_IDLE |=> !strobe) else $error("byte strobed before frame began");
  a_one_env_shift : assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctrl.env_shift) && !(ctrl.dest_shift && ctrl.env_shift != 4'd0))
    else $error("more than one shifter advanced");
`endif

endmodule

/* rtl/telemetry_frame_serializer.sv */
// Top level of the telemetry frame serializer: configuration registers,
// byte shifters and sequencer. Depends on tfs_pkg, tfs_byte_shifter, tfs_sequencer.
//
//   Channel   Handshake                   Payload
//   -------   -------------------------   ------------------------------------------
//   sample    start, busy (take: start    temperature_bits, humidity_bits,
//             high while busy is low)     pressure_bits, illuminance_bits
//   frame     byte_valid (one cycle,      byte_out, last_byte
//             cannot be stalled)
//   config    cfg_valid, cfg_ready        cfg_index, cfg_data
//
// A request occupies the block from the moment it is taken until the last byte is
// shown. The sequencer emits one byte per cycle, except while an environment field
// that is NaN is skipped with no byte. After the request is taken the sequencer
// enters its header state, then registers the first byte and its strobe; busy
// falls in the cycle in which the last byte is shown. Reset (rst, synchronous)
// restores the register defaults and idles the sequencer. The frame receiver
// cannot stall the block; configuration writes are always accepted.
module telemetry_frame_serializer
  import tfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] temperature_bits,
  input  logic [31:0] humidity_bits,
  input  logic [31:0] pressure_bits,
  input  logic [31:0] illuminance_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        byte_valid,
  output logic [7:0]  byte_out,
  output logic        last_byte
);

  logic [31:0]      dest_address;
  logic [6:0]       hop_budget;
  logic [6:0]       port_number;
  logic [3:0]       present;
  logic [31:0]      sample_word [4];
  logic [3:0][7:0]  env_byte;
  logic [7:0]       dest_byte;
  shift_ctrl_t      ctrl;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_address <= DEST_RESET;
      hop_budget   <= HOP_RESET;
      port_number  <= PORT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEST_ADDRESS: dest_address <= cfg_data;
        CFG_HOP_BUDGET:   hop_budget   <= cfg_data[6:0];
        CFG_PORT_NUMBER:  port_number  <= cfg_data[6:0];
        default:          ;
      endcase
    end
  end

  assign sample_word[0] = temperature_bits;
  assign sample_word[1] = humidity_bits;
  assign sample_word[2] = pressure_bits;
  assign sample_word[3] = illuminance_bits;

  // A field is absent when its exponent is all ones and its mantissa is
  // nonzero; infinities are still sent.
  for (genvar g = 0; g < 4; g++) begin : g_env
    assign present[g] = !((sample_word[g][30:23] == 8'hFF) &&
                          (sample_word[g][22:0] != 23'd0));

    tfs_byte_shifter u_env_shifter (
      .clk       (clk),
      .load      (ctrl.load),
      .load_word (sample_word[g]),
      .shift     (ctrl.env_shift[g]),
      .low_byte  (env_byte[g])
    );
  end

  // The destination goes out little-endian, one byte per cycle.
  tfs_byte_shifter u_dest_shifter (
    .clk       (clk),
    .load      (ctrl.load),
    .load_word (dest_address),
    .shift     (ctrl.dest_shift),
    .low_byte  (dest_byte)
  );

  tfs_sequencer u_sequencer (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .present_in  (present),
    .hop_budget  (hop_budget),
    .port_number (port_number),
    .dest_byte   (dest_byte),
    .env_byte    (env_byte),
    .ctrl        (ctrl),
    .busy        (busy),
    .strobe      (byte_valid),
    .byte_out    (byte_out),
    .last_byte   (last_byte)
  );

endmodule
